// ===== rtl/core/zsaf_pkg.sv =====
`default_nettype none
package zsaf_pkg;

   // command codes
   localparam logic [2:0] FN_OPEN   = 3'd0;
   localparam logic [2:0] FN_BEGIN  = 3'd1;
   localparam logic [2:0] FN_NAME   = 3'd2;
   localparam logic [2:0] FN_DATA   = 3'd3;
   localparam logic [2:0] FN_END    = 3'd4;
   localparam logic [2:0] FN_FINISH = 3'd5;
   localparam logic [2:0] FN_ABORT  = 3'd6;

   // record kinds
   localparam logic [2:0] RK_NONE   = 3'd0;
   localparam logic [2:0] RK_SINGLE = 3'd1;
   localparam logic [2:0] RK_LOCAL  = 3'd2;
   localparam logic [2:0] RK_PATCH  = 3'd3;
   localparam logic [2:0] RK_CEN    = 3'd4;
   localparam logic [2:0] RK_EOCD   = 3'd5;

   // result status
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_REJ  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // register map, selected by paddr bit 2
   localparam int         CSR_AW   = 3;
   localparam logic       REG_TIME = 1'b0;
   localparam logic       REG_DATE = 1'b1;

   localparam logic [15:0] STAMP_TIME_RST = 16'h0000;
   localparam logic [15:0] STAMP_DATE_RST = 16'h0021;

   localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
   localparam logic [31:0] SIG_LOCAL  = 32'h04034b50;
   localparam logic [31:0] SIG_CEN    = 32'h02014b50;
   localparam logic [31:0] SIG_EOCD   = 32'h06054b50;
   localparam logic [15:0] ZIP_VER    = 16'd20;
   localparam logic [31:0] PATCH_GAP  = 32'd14;
   localparam logic [6:0]  LEN_LOCAL  = 7'd30;
   localparam logic [6:0]  LEN_PATCH  = 7'd12;
   localparam logic [6:0]  LEN_CEN    = 7'd46;
   localparam logic [6:0]  LEN_EOCD   = 7'd22;

   typedef struct packed {
      logic [15:0] stamp_time;
      logic [15:0] stamp_date;
   } cfg_type;

   typedef struct packed {
      logic exec;
      logic load;
      logic put;
      logic push;
   } ctrl_cmd_type;

   typedef struct packed {
      logic load_needed;
      logic need_name;
      logic grp_full;
      logic last;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== rtl/core/zsaf_req_if.sv =====
`default_nettype none
interface zsaf_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] func;
   logic [7:0] in_byte;
   logic [5:0] name_length;

   modport source (output valid, func, in_byte, name_length, input ready);
   modport sink (input valid, func, in_byte, name_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/zsaf_rsp_if.sv =====
`default_nettype none
interface zsaf_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_bytes;
   logic [3:0]  out_count;
   logic [31:0] out_offset;
   logic        out_last;
   logic [1:0]  status;

   modport source (output valid, out_bytes, out_count, out_offset, out_last, status,
                   input ready);
   modport sink (input valid, out_bytes, out_count, out_offset, out_last, status,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/core/zip_stored_archive_framer_core.sv =====
// channel    | dir | handshake                 | payload
// req_chan   | in  | valid/ready               | func, in_byte, name_length
// rsp_chan   | out | valid/ready               | out_bytes, out_count, out_offset,
//            |     |                           | out_last, status
// csr_*      | in  | apb write, pready tied hi | time word @0, date word @4
//
// a command is taken in S_IDLE, then its record is built one byte a cycle into a
// word of up to eight bytes, but each name byte waits on the name memory read port;
// a central record first loads its entry from the tables. once a word is complete
// the controller moves to S_PUSH and loads it into the result register. synchronous
// reset clears the archive state and the csr registers; memories and the record and
// result data registers are not cleared. a stalled rsp holds the word and the byte
// assembler until it is taken.
`default_nettype none
module zip_stored_archive_framer_core
   import zsaf_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int NAME_CAP    = 64
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   zsaf_req_if.sink               req_chan,
   zsaf_rsp_if.source             rsp_chan,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type st;

   zsaf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   zsaf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .st        (st),
      .cmd       (cmd)
   );

   zsaf_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .NAME_CAP    (NAME_CAP)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .st              (st),
      .req_func        (req_chan.func),
      .req_in_byte     (req_chan.in_byte),
      .req_name_length (req_chan.name_length),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_out_bytes   (rsp_chan.out_bytes),
      .rsp_out_count   (rsp_chan.out_count),
      .rsp_out_offset  (rsp_chan.out_offset),
      .rsp_out_last    (rsp_chan.out_last),
      .rsp_status      (rsp_chan.status)
   );

endmodule
`default_nettype wire

// ===== rtl/core/zsaf_csr.sv =====
`default_nettype none
module zsaf_csr
   import zsaf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready,
   output cfg_type                cfg
);

   logic [15:0] stamp_time_ff, stamp_time_in;
   logic [15:0] stamp_date_ff, stamp_date_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      stamp_time_in = stamp_time_ff;
      stamp_date_in = stamp_date_ff;
      if (wr_en) begin
         if (csr_paddr[2] == REG_TIME) stamp_time_in = csr_pwdata[15:0];
         else stamp_date_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_time_ff <= STAMP_TIME_RST;
         stamp_date_ff <= STAMP_DATE_RST;
      end else begin
         stamp_time_ff <= stamp_time_in;
         stamp_date_ff <= stamp_date_in;
      end
   end

   assign csr_prdata      = (csr_paddr[2] == REG_TIME) ? {16'h0000, stamp_time_ff}
                                                       : {16'h0000, stamp_date_ff};
   assign cfg.stamp_time  = stamp_time_ff;
   assign cfg.stamp_date  = stamp_date_ff;

endmodule
`default_nettype wire

// ===== rtl/core/zsaf_ctrl.sv =====
`default_nettype none
module zsaf_ctrl
   import zsaf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  dp_status_type      st,
   output ctrl_cmd_type       cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD  = 3'd1;
   localparam logic [2:0] S_BYTE  = 3'd2;
   localparam logic [2:0] S_NAMEW = 3'd3;
   localparam logic [2:0] S_PUSH  = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.exec = 1'b1;
               state_in = st.load_needed ? S_LOAD : S_BYTE;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_BYTE;
         end
         S_BYTE: begin
            if (st.grp_full) begin
               state_in = S_PUSH;
            end else if (st.need_name) begin
               // name bytes come from memory: wait in S_NAMEW for the registered read data
               state_in = S_NAMEW;
            end else begin
               cmd.put = 1'b1;
            end
         end
         S_NAMEW: begin
            cmd.put  = 1'b1;
            state_in = S_BYTE;
         end
         S_PUSH: begin
            if (st.out_free) begin
               cmd.push = 1'b1;
               state_in = st.last ? S_IDLE : S_BYTE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   a_name_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BYTE && !st.grp_full && st.need_name) |=> (state_ff == S_NAMEW))
      else $error("name byte taken without read wait");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && st.last) |=> (state_ff == S_IDLE))
      else $error("controller busy after last word");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.exec, cmd.load, cmd.put, cmd.push}))
      else $error("several datapath commands at once");

endmodule
`default_nettype wire

// ===== rtl/core/zsaf_datapath.sv =====
`default_nettype none
module zsaf_datapath
   import zsaf_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int NAME_CAP    = 64
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  cfg_type          cfg,
   input  ctrl_cmd_type     cmd,
   output dp_status_type    st,
   input  wire logic [2:0]  req_func,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic [5:0]  req_name_length,
   input  wire logic        rsp_ready,
   output logic             rsp_valid,
   output logic [63:0]      rsp_out_bytes,
   output logic [3:0]       rsp_out_count,
   output logic [31:0]      rsp_out_offset,
   output logic             rsp_out_last,
   output logic [1:0]       rsp_status
);

   localparam int ECW = $clog2(MAX_ENTRIES + 1);
   localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int AW  = $clog2(MAX_ENTRIES * NAME_CAP);

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = ~crc ^ {24'h000000, b};
      for (int k = 0; k < 8; k++) c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      return ~c;
   endfunction

   // archive state
   logic           archive_open_ff, archive_open_in;
   logic           entry_open_ff, entry_open_in;
   logic [31:0]    write_offset_ff, write_offset_in;
   logic [31:0]    running_crc_ff, running_crc_in;
   logic [31:0]    byte_count_ff, byte_count_in;
   logic [31:0]    header_off_ff, header_off_in;
   logic [5:0]     pending_ff, pending_in;
   logic [5:0]     names_ff, names_in;
   logic [ECW-1:0] entry_count_ff, entry_count_in;
   logic [ECW-1:0] dir_idx_ff, dir_idx_in;
   logic [31:0]    dir_start_ff, dir_start_in;

   // record being emitted
   logic [2:0]     rec_kind_ff;
   logic [6:0]     rec_len_ff;
   logic [31:0]    rec_off_ff;
   logic [1:0]     rec_status_ff;
   logic [ECW-1:0] rec_entry_ff;
   logic [7:0]     rec_byte_ff;
   logic [31:0]    rec_crc_ff, rec_size_ff, rec_eoff_ff, rec_dsize_ff, rec_dstart_ff;
   logic [5:0]     rec_nl_ff;
   logic [15:0]    rec_count_ff;
   cfg_type        rec_cfg_ff;
   logic [6:0]     pos_ff;
   logic [63:0]    grp_bytes_ff;
   logic [3:0]     grp_cnt_ff;

   // exec decode
   logic [2:0]     kind_x;
   logic [1:0]     status_x;
   logic [31:0]    off_x;
   logic [6:0]     len_x;
   logic [31:0]    dstart_x;
   logic [31:0]    crc_next;
   logic           begin_bad, body_bad;
   logic           name_we, tab_we;

   // memories
   logic [7:0]     name_mem [MAX_ENTRIES*NAME_CAP];
   logic [31:0]    crc_mem  [MAX_ENTRIES];
   logic [31:0]    size_mem [MAX_ENTRIES];
   logic [31:0]    off_mem  [MAX_ENTRIES];
   logic [5:0]     nl_mem   [MAX_ENTRIES];
   logic [AW-1:0]  name_waddr, name_raddr;
   logic [7:0]     name_rd_ff;
   logic [31:0]    crc_rd_ff, size_rd_ff, off_rd_ff;
   logic [5:0]     nl_rd_ff;

   logic [8*46-1:0] rec_vec;
   logic [8:0]      bitpos;
   logic [7:0]      hdr_byte, byte_sel;
   logic [6:0]      name_pos;
   logic            out_free;

   always_comb begin
      archive_open_in = archive_open_ff;
      entry_open_in   = entry_open_ff;
      write_offset_in = write_offset_ff;
      running_crc_in  = running_crc_ff;
      byte_count_in   = byte_count_ff;
      header_off_in   = header_off_ff;
      pending_in      = pending_ff;
      names_in        = names_ff;
      entry_count_in  = entry_count_ff;
      dir_idx_in      = dir_idx_ff;
      dir_start_in    = dir_start_ff;
      kind_x          = RK_NONE;
      status_x        = ST_OK;
      off_x           = write_offset_ff;
      len_x           = '0;
      name_we         = 1'b0;
      tab_we          = 1'b0;
      dstart_x        = (dir_idx_ff == '0) ? write_offset_ff : dir_start_ff;
      crc_next        = crc_byte(running_crc_ff, req_in_byte);
      begin_bad       = !archive_open_ff || entry_open_ff || (dir_idx_ff != '0) ||
                        (entry_count_ff >= ECW'(MAX_ENTRIES)) || (req_name_length == '0) ||
                        (32'(req_name_length) >= 32'(NAME_CAP));
      body_bad        = !entry_open_ff || (names_ff != pending_ff);
      if (cmd.exec) begin
         case (req_func)
            FN_OPEN: begin
               if (archive_open_ff) begin
                  status_x = ST_REJ;
               end else begin
                  archive_open_in = 1'b1;
                  entry_open_in   = 1'b0;
                  write_offset_in = '0;
                  running_crc_in  = '0;
                  byte_count_in   = '0;
                  header_off_in   = '0;
                  pending_in      = '0;
                  names_in        = '0;
                  entry_count_in  = '0;
                  dir_idx_in      = '0;
                  dir_start_in    = '0;
                  off_x           = '0;
               end
            end
            FN_BEGIN: begin
               if (begin_bad) begin
                  status_x = ST_REJ;
               end else begin
                  kind_x          = RK_LOCAL;
                  len_x           = LEN_LOCAL;
                  header_off_in   = write_offset_ff;
                  pending_in      = req_name_length;
                  names_in        = '0;
                  running_crc_in  = '0;
                  byte_count_in   = '0;
                  entry_open_in   = 1'b1;
                  write_offset_in = write_offset_ff + 32'(LEN_LOCAL);
               end
            end
            FN_NAME: begin
               if (!entry_open_ff || (names_ff >= pending_ff)) begin
                  status_x = ST_REJ;
               end else begin
                  kind_x          = RK_SINGLE;
                  len_x           = 7'd1;
                  name_we         = 1'b1;
                  names_in        = names_ff + 6'd1;
                  write_offset_in = write_offset_ff + 32'd1;
               end
            end
            FN_DATA: begin
               if (body_bad) begin
                  status_x = ST_REJ;
               end else begin
                  kind_x          = RK_SINGLE;
                  len_x           = 7'd1;
                  running_crc_in  = crc_next;
                  byte_count_in   = byte_count_ff + 32'd1;
                  write_offset_in = write_offset_ff + 32'd1;
               end
            end
            FN_END: begin
               if (body_bad) begin
                  status_x = ST_REJ;
               end else begin
                  kind_x        = RK_PATCH;
                  len_x         = LEN_PATCH;
                  off_x         = header_off_ff + PATCH_GAP;
                  entry_open_in = 1'b0;
                  if (entry_count_ff < ECW'(MAX_ENTRIES)) begin
                     tab_we         = 1'b1;
                     entry_count_in = entry_count_ff + ECW'(1);
                  end
               end
            end
            FN_FINISH: begin
               if (!archive_open_ff || entry_open_ff) begin
                  status_x = ST_REJ;
               end else begin
                  dir_start_in = dstart_x;
                  if (dir_idx_ff < entry_count_ff) begin
                     // length and offset step are known once the tables are read
                     kind_x     = RK_CEN;
                     dir_idx_in = dir_idx_ff + ECW'(1);
                  end else begin
                     kind_x          = RK_EOCD;
                     len_x           = LEN_EOCD;
                     status_x        = ST_DONE;
                     write_offset_in = write_offset_ff + 32'(LEN_EOCD);
                     archive_open_in = 1'b0;
                  end
               end
            end
            FN_ABORT: begin
               archive_open_in = 1'b0;
               entry_open_in   = 1'b0;
               entry_count_in  = '0;
               dir_idx_in      = '0;
               pending_in      = '0;
               names_in        = '0;
            end
            default: status_x = ST_REJ;
         endcase
      end
      if (cmd.load && rec_kind_ff == RK_CEN) begin
         write_offset_in = write_offset_ff + 32'(LEN_CEN) + 32'(nl_rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         archive_open_ff <= 1'b0;
         entry_open_ff   <= 1'b0;
         write_offset_ff <= '0;
         running_crc_ff  <= '0;
         byte_count_ff   <= '0;
         header_off_ff   <= '0;
         pending_ff      <= '0;
         names_ff        <= '0;
         entry_count_ff  <= '0;
         dir_idx_ff      <= '0;
         dir_start_ff    <= '0;
      end else begin
         archive_open_ff <= archive_open_in;
         entry_open_ff   <= entry_open_in;
         write_offset_ff <= write_offset_in;
         running_crc_ff  <= running_crc_in;
         byte_count_ff   <= byte_count_in;
         header_off_ff   <= header_off_in;
         pending_ff      <= pending_in;
         names_ff        <= names_in;
         entry_count_ff  <= entry_count_in;
         dir_idx_ff      <= dir_idx_in;
         dir_start_ff    <= dir_start_in;
      end
   end

   // name store and entry tables
   assign name_waddr = AW'(entry_count_ff) * AW'(NAME_CAP) + AW'(names_ff);
   assign name_pos   = pos_ff - LEN_CEN;
   assign name_raddr = AW'(rec_entry_ff) * AW'(NAME_CAP) + AW'(name_pos);

   always_ff @(posedge clock) begin
      if (name_we) name_mem[name_waddr] <= req_in_byte;
      name_rd_ff <= name_mem[name_raddr];
   end

   always_ff @(posedge clock) begin
      if (tab_we) begin
         crc_mem[entry_count_ff[EW-1:0]]  <= running_crc_ff;
         size_mem[entry_count_ff[EW-1:0]] <= byte_count_ff;
         off_mem[entry_count_ff[EW-1:0]]  <= header_off_ff;
         nl_mem[entry_count_ff[EW-1:0]]   <= pending_ff;
      end
      crc_rd_ff  <= crc_mem[dir_idx_ff[EW-1:0]];
      size_rd_ff <= size_mem[dir_idx_ff[EW-1:0]];
      off_rd_ff  <= off_mem[dir_idx_ff[EW-1:0]];
      nl_rd_ff   <= nl_mem[dir_idx_ff[EW-1:0]];
   end

   // record byte image
   always_comb begin
      rec_vec = '0;
      case (rec_kind_ff)
         RK_SINGLE: rec_vec[7:0] = rec_byte_ff;
         RK_LOCAL: begin
            rec_vec[31:0]    = SIG_LOCAL;
            rec_vec[47:32]   = ZIP_VER;
            rec_vec[95:80]   = rec_cfg_ff.stamp_time;
            rec_vec[111:96]  = rec_cfg_ff.stamp_date;
            rec_vec[223:208] = 16'(rec_nl_ff);
         end
         RK_PATCH: begin
            rec_vec[31:0]  = rec_crc_ff;
            rec_vec[63:32] = rec_size_ff;
            rec_vec[95:64] = rec_size_ff;
         end
         RK_CEN: begin
            rec_vec[31:0]    = SIG_CEN;
            rec_vec[47:32]   = ZIP_VER;
            rec_vec[63:48]   = ZIP_VER;
            rec_vec[111:96]  = rec_cfg_ff.stamp_time;
            rec_vec[127:112] = rec_cfg_ff.stamp_date;
            rec_vec[159:128] = rec_crc_ff;
            rec_vec[191:160] = rec_size_ff;
            rec_vec[223:192] = rec_size_ff;
            rec_vec[239:224] = 16'(rec_nl_ff);
            rec_vec[367:336] = rec_eoff_ff;
         end
         RK_EOCD: begin
            rec_vec[31:0]    = SIG_EOCD;
            rec_vec[79:64]   = rec_count_ff;
            rec_vec[95:80]   = rec_count_ff;
            rec_vec[127:96]  = rec_dsize_ff;
            rec_vec[159:128] = rec_dstart_ff;
         end
         default: rec_vec = '0;
      endcase
   end

   assign bitpos   = {pos_ff[5:0], 3'b000};
   assign hdr_byte = (pos_ff < LEN_CEN) ? rec_vec[bitpos +: 8] : 8'h00;
   assign byte_sel = st.need_name ? name_rd_ff : hdr_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_kind_ff <= RK_NONE;
         rec_len_ff  <= '0;
      end else if (cmd.exec) begin
         rec_kind_ff   <= kind_x;
         rec_len_ff    <= len_x;
         rec_off_ff    <= off_x;
         rec_status_ff <= status_x;
         rec_entry_ff  <= dir_idx_ff;
         rec_byte_ff   <= req_in_byte;
         rec_crc_ff    <= running_crc_ff;
         rec_size_ff   <= byte_count_ff;
         rec_eoff_ff   <= header_off_ff;
         rec_nl_ff     <= req_name_length;
         rec_count_ff  <= 16'(entry_count_ff);
         rec_dsize_ff  <= write_offset_ff - dstart_x;
         rec_dstart_ff <= dstart_x;
         rec_cfg_ff    <= cfg;
      end else if (cmd.load && rec_kind_ff == RK_CEN) begin
         rec_len_ff  <= LEN_CEN + 7'(nl_rd_ff);
         rec_crc_ff  <= crc_rd_ff;
         rec_size_ff <= size_rd_ff;
         rec_eoff_ff <= off_rd_ff;
         rec_nl_ff   <= nl_rd_ff;
      end
   end

   // word assembly
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         grp_cnt_ff   <= '0;
         grp_bytes_ff <= '0;
      end else if (cmd.exec) begin
         pos_ff       <= '0;
         grp_cnt_ff   <= '0;
         grp_bytes_ff <= '0;
      end else if (cmd.put) begin
         pos_ff       <= pos_ff + 7'd1;
         grp_cnt_ff   <= grp_cnt_ff + 4'd1;
         grp_bytes_ff <= grp_bytes_ff | (64'(byte_sel) << {grp_cnt_ff[2:0], 3'b000});
      end else if (cmd.push) begin
         grp_cnt_ff   <= '0;
         grp_bytes_ff <= '0;
      end
   end

   // result register
   assign out_free = !rsp_valid || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (cmd.push) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_out_bytes  <= grp_bytes_ff;
         rsp_out_count  <= grp_cnt_ff;
         rsp_out_offset <= rec_off_ff + 32'(pos_ff) - 32'(grp_cnt_ff);
         rsp_out_last   <= (pos_ff == rec_len_ff);
         rsp_status     <= rec_status_ff;
      end
   end

   assign st.load_needed = (kind_x == RK_CEN);
   assign st.need_name   = (rec_kind_ff == RK_CEN) && (pos_ff >= LEN_CEN);
   assign st.grp_full    = (grp_cnt_ff == 4'd8) || (pos_ff == rec_len_ff);
   assign st.last        = (pos_ff == rec_len_ff);
   assign st.out_free    = out_free;

   a_entry_in_archive: assert property (@(posedge clock) disable iff (reset)
      entry_open_ff |-> archive_open_ff)
      else $error("entry open outside an archive");
   a_names_bound: assert property (@(posedge clock) disable iff (reset)
      names_ff <= pending_ff)
      else $error("more name bytes than announced");
   a_dir_bound: assert property (@(posedge clock) disable iff (reset)
      dir_idx_ff <= entry_count_ff)
      else $error("directory walk beyond entry count");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (pos_ff <= rec_len_ff || rec_kind_ff == RK_CEN) && grp_cnt_ff <= 4'd8)
      else $error("record position overrun");

endmodule
`default_nettype wire
